/* rtl/sof_pkg.sv */
`default_nettype none

package sof_pkg;

	localparam int TSTEP_W = 17;
	localparam int COEF_W = 31;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 4;
	localparam int MUL_DIGIT = 4;

	localparam logic [1:0] REG_DAMPING = 2'd0;
	localparam logic [1:0] REG_INERTIA = 2'd1;
	localparam logic [1:0] REG_RESPONSE = 2'd2;

	localparam logic [COEF_W-1:0] DAMPING_RST = 31'd10430;
	localparam logic [COEF_W-1:0] INERTIA_RST = 31'd415;
	localparam logic [COEF_W-1:0] RESPONSE_RST = 31'd2608;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TSQ,
		ST_LIM,
		ST_DX,
		ST_VT,
		ST_K3,
		ST_K1,
		ST_DV,
		ST_OUT
	} sof_state_t;

	typedef enum logic [2:0] {
		MD_IDLE,
		MD_MUL,
		MD_CHK,
		MD_DIV,
		MD_SAT
	} md_state_t;

	typedef struct packed {
		logic start;
		logic div_mode;
	} md_ctrl_t;

endpackage

`default_nettype wire

/* rtl/sof_muldiv.sv */
`default_nettype none

module sof_muldiv #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS = 16,
	parameter int A_WIDTH = 34,
	parameter int B_WIDTH = 31,
	parameter int C_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sof_pkg::md_ctrl_t            ctrl,
	input  logic signed [A_WIDTH-1:0]    op_a,
	input  logic [B_WIDTH-1:0]           op_b,
	input  logic [C_WIDTH-1:0]           op_c,
	output logic                         done,
	output logic signed [DATA_WIDTH-1:0] result
);
	import sof_pkg::*;

	localparam int NDIG = (B_WIDTH + MUL_DIGIT - 1) / MUL_DIGIT;
	localparam int BPW = NDIG * MUL_DIGIT;
	localparam int PW = A_WIDTH + BPW;
	localparam int HW = PW - DATA_WIDTH;
	localparam int XW = (HW > C_WIDTH) ? HW : C_WIDTH;
	localparam int PPW = A_WIDTH + MUL_DIGIT;
	localparam int CNT_MAX = (DATA_WIDTH > NDIG) ? DATA_WIDTH : NDIG;
	localparam int CNTW = $clog2(CNT_MAX);
	localparam logic [DATA_WIDTH-1:0] POS_LIM = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic [DATA_WIDTH-1:0] NEG_LIM = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	md_state_t st_q, st_d;

	logic                  neg_q;
	logic                  div_q;
	logic                  ovf_q;
	logic [A_WIDTH-1:0]    mag_q;
	logic [BPW-1:0]        mb_q;
	logic [C_WIDTH-1:0]    c_q;
	logic [C_WIDTH-1:0]    rem_q;
	logic [PW-1:0]         prod_q;
	logic [CNTW-1:0]       cnt_q;
	logic                  done_q;
	logic signed [DATA_WIDTH-1:0] res_q;

	logic [A_WIDTH-1:0]    a_mag;
	logic [MUL_DIGIT-1:0]  digit;
	logic [PPW-1:0]        pp;
	logic [PW-1:0]         acc_next;
	logic [XW-1:0]         hi_ext;
	logic [XW-1:0]         c_ext;
	logic                  ovf_div;
	logic                  ovf_shift;
	logic [C_WIDTH:0]      trial;
	logic [C_WIDTH:0]      trial_diff;
	logic                  trial_ge;
	logic [C_WIDTH-1:0]    rem_next;
	logic [DATA_WIDTH-1:0] lim;
	logic [DATA_WIDTH-1:0] q_sat;

	assign a_mag = op_a[A_WIDTH-1] ? A_WIDTH'(-op_a) : A_WIDTH'(op_a);

	// The multiplier is consumed one digit a cycle, most significant first.
	assign digit = mb_q[BPW-1 -: MUL_DIGIT];
	assign pp = PPW'(mag_q) * PPW'(digit);
	assign acc_next = {prod_q[PW-MUL_DIGIT-1:0], {MUL_DIGIT{1'b0}}} + PW'(pp);

	// The quotient fits in DATA_WIDTH bits only if the bits above it are below the divisor.
	assign hi_ext = XW'(prod_q[PW-1:DATA_WIDTH]);
	assign c_ext = XW'(c_q);
	assign ovf_div = (hi_ext >= c_ext);
	assign ovf_shift = |prod_q[PW-1:FRAC_BITS+DATA_WIDTH];

	assign trial = {rem_q, prod_q[DATA_WIDTH-1]};
	assign trial_diff = trial - {1'b0, c_q};
	assign trial_ge = (trial >= {1'b0, c_q});
	assign rem_next = trial_ge ? trial_diff[C_WIDTH-1:0] : trial[C_WIDTH-1:0];

	assign lim = neg_q ? NEG_LIM : POS_LIM;
	assign q_sat = (ovf_q || (prod_q[DATA_WIDTH-1:0] > lim)) ? lim : prod_q[DATA_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= MD_IDLE;
			done_q <= 1'b0;
		end else begin
			st_q <= st_d;
			done_q <= (st_q == MD_SAT);
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			MD_IDLE: begin
				if (ctrl.start) begin
					st_d = MD_MUL;
				end
			end
			MD_MUL: begin
				if (cnt_q == '0) begin
					st_d = MD_CHK;
				end
			end
			MD_CHK: begin
				if (div_q && !ovf_div) begin
					st_d = MD_DIV;
				end else begin
					st_d = MD_SAT;
				end
			end
			MD_DIV: begin
				if (cnt_q == '0) begin
					st_d = MD_SAT;
				end
			end
			MD_SAT: begin
				st_d = MD_IDLE;
			end
			default: begin
				st_d = MD_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			MD_IDLE: begin
				if (ctrl.start) begin
					neg_q <= op_a[A_WIDTH-1];
					mag_q <= a_mag;
					mb_q <= BPW'(op_b);
					div_q <= ctrl.div_mode;
					c_q <= (op_c == '0) ? C_WIDTH'(1) : op_c;
					prod_q <= '0;
					cnt_q <= CNTW'(NDIG - 1);
				end
			end
			MD_MUL: begin
				prod_q <= acc_next;
				mb_q <= mb_q << MUL_DIGIT;
				cnt_q <= cnt_q - CNTW'(1);
			end
			MD_CHK: begin
				if (!div_q) begin
					prod_q[DATA_WIDTH-1:0] <= prod_q[FRAC_BITS +: DATA_WIDTH];
					ovf_q <= ovf_shift;
				end else begin
					ovf_q <= ovf_div;
					rem_q <= hi_ext[C_WIDTH-1:0];
					cnt_q <= CNTW'(DATA_WIDTH - 1);
				end
			end
			MD_DIV: begin
				rem_q <= rem_next;
				prod_q[DATA_WIDTH-1:0] <= {prod_q[DATA_WIDTH-2:0], trial_ge};
				cnt_q <= cnt_q - CNTW'(1);
			end
			MD_SAT: begin
				res_q <= neg_q ? -q_sat : q_sat;
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign result = res_q;

endmodule

`default_nettype wire

/* rtl/second_order_follower_top.sv */
`default_nettype none

// Second-order follower: each item (target, step_time) advances a position and
// velocity by one semi-implicit Euler step toward the target, with k2 raised to
// the stability floor 1.1*(T*T/4 + k1/2) when needed (flag stabilized). All
// values are signed fixed point with FRAC_BITS fraction bits; results saturate.
// Every item runs seven multiply-shift or multiply-divide operations through one
// shared iterative unit that takes 4 multiplier bits a cycle and one quotient bit
// a cycle, with NDIG = 8 multiplier digits. A division whose quotient saturates
// skips its quotient steps, and a result that cannot enter the output register
// holds the block in its last state until it can. in_ready is high only between
// items, and one finished result can wait in the output register meanwhile.
// Coefficients k1, k2, k3 are written over the APB port at byte addresses 0, 4, 8
// and should only be changed while the block is idle.
module second_order_follower_top #(
	parameter int FRAC_BITS = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [31:0]               target,
	input  logic [sof_pkg::TSTEP_W-1:0]      step_time,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [31:0]               position,
	output logic signed [31:0]               velocity,
	output logic                             stabilized,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [sof_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [sof_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [sof_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready
);
	import sof_pkg::*;

	localparam int DW = DATA_WIDTH;
	localparam int AW = DW + 2;
	localparam int BW = (FRAC_BITS + 2 > COEF_W) ? FRAC_BITS + 2 : COEF_W;
	localparam int CW = (DW > BW) ? DW : BW;
	localparam int XW = (DW > 32) ? DW : 32;
	localparam int WW = XW + 2;

	localparam logic [BW-1:0] FX_ONE_B = BW'(1) << FRAC_BITS;
	localparam logic [BW-1:0] C11_B = BW'((11 * (64'(1) << FRAC_BITS) + 5) / 10);
	localparam logic signed [WW-1:0] DW_MAX_W = (WW'(1) << (DW - 1)) - WW'(1);
	localparam logic signed [WW-1:0] DW_MIN_W = ~DW_MAX_W;
	localparam logic signed [WW-1:0] O_MAX_W = (WW'(1) << 31) - WW'(1);
	localparam logic signed [WW-1:0] O_MIN_W = ~O_MAX_W;

	function automatic logic signed [DW-1:0] sat_dw(input logic signed [WW-1:0] v);
		logic signed [WW-1:0] r;
		if (v > DW_MAX_W) begin
			r = DW_MAX_W;
		end else if (v < DW_MIN_W) begin
			r = DW_MIN_W;
		end else begin
			r = v;
		end
		return r[DW-1:0];
	endfunction

	function automatic logic signed [31:0] sat_out(input logic signed [WW-1:0] v);
		logic signed [WW-1:0] r;
		if (v > O_MAX_W) begin
			r = O_MAX_W;
		end else if (v < O_MIN_W) begin
			r = O_MIN_W;
		end else begin
			r = v;
		end
		return r[31:0];
	endfunction

	sof_state_t st_q, st_d;

	logic [COEF_W-1:0] k1_q, k2_q, k3_q;
	logic [1:0]        reg_idx;
	logic              cfg_wr;

	logic signed [DW-1:0] prev_q, pos_q, vel_q;
	logic signed [DW-1:0] x_q, sum_q, dx_q, y1_q;
	logic [TSTEP_W-1:0]   t_q;
	logic [CW-1:0]        k2eff_q;
	logic                 stab_q;
	logic signed [AW-1:0] acc_q;
	logic                 issued_q;
	logic                 out_valid_q;
	logic signed [31:0]   position_q, velocity_q;
	logic                 stabilized_q;

	md_ctrl_t             md_ctrl;
	logic                 is_op;
	logic signed [AW-1:0] md_a;
	logic [BW-1:0]        md_b;
	logic [CW-1:0]        md_c;
	logic                 md_done;
	logic signed [DW-1:0] md_result;

	logic                 in_fire;
	logic                 out_load;
	logic [TSTEP_W-1:0]   t_clamped;
	logic                 k2_below;

	// Configuration port.
	assign pready = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k1_q <= DAMPING_RST;
			k2_q <= INERTIA_RST;
			k3_q <= RESPONSE_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_DAMPING: k1_q <= pwdata[COEF_W-1:0];
				REG_INERTIA: k2_q <= pwdata[COEF_W-1:0];
				REG_RESPONSE: k3_q <= pwdata[COEF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_DAMPING: prdata = APB_DATA_W'(k1_q);
			REG_INERTIA: prdata = APB_DATA_W'(k2_q);
			REG_RESPONSE: prdata = APB_DATA_W'(k3_q);
			default: prdata = '0;
		endcase
	end

	// A zero step counts as one LSB and a step above one second is cut to one second.
	always_comb begin
		if (step_time == '0) begin
			t_clamped = TSTEP_W'(1);
		end else if (BW'(step_time) > FX_ONE_B) begin
			t_clamped = FX_ONE_B[TSTEP_W-1:0];
		end else begin
			t_clamped = step_time;
		end
	end

	assign in_ready = (st_q == ST_IDLE);
	assign in_fire = in_valid && in_ready;
	assign out_load = (st_q == ST_OUT) && (!out_valid_q || out_ready);
	assign k2_below = WW'($signed({1'b0, k2_q})) < WW'(md_result);

	always_comb begin
		st_d = st_q;
		is_op = 1'b0;
		md_a = '0;
		md_b = '0;
		md_c = '0;
		md_ctrl.div_mode = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				if (in_valid) begin
					st_d = ST_TSQ;
				end
			end
			ST_TSQ: begin
				is_op = 1'b1;
				md_a = AW'(t_q);
				md_b = BW'(t_q);
				if (md_done) begin
					st_d = ST_LIM;
				end
			end
			ST_LIM: begin
				is_op = 1'b1;
				md_a = AW'(sum_q);
				md_b = C11_B;
				if (md_done) begin
					st_d = ST_DX;
				end
			end
			ST_DX: begin
				is_op = 1'b1;
				md_a = AW'(x_q) - AW'(prev_q);
				md_b = FX_ONE_B;
				md_c = CW'(t_q);
				md_ctrl.div_mode = 1'b1;
				if (md_done) begin
					st_d = ST_VT;
				end
			end
			ST_VT: begin
				is_op = 1'b1;
				md_a = AW'(vel_q);
				md_b = BW'(t_q);
				if (md_done) begin
					st_d = ST_K3;
				end
			end
			ST_K3: begin
				is_op = 1'b1;
				md_a = AW'(dx_q);
				md_b = BW'(k3_q);
				if (md_done) begin
					st_d = ST_K1;
				end
			end
			ST_K1: begin
				is_op = 1'b1;
				md_a = AW'(vel_q);
				md_b = BW'(k1_q);
				if (md_done) begin
					st_d = ST_DV;
				end
			end
			ST_DV: begin
				is_op = 1'b1;
				md_a = acc_q;
				md_b = BW'(t_q);
				md_c = k2eff_q;
				md_ctrl.div_mode = 1'b1;
				if (md_done) begin
					st_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					st_d = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
		md_ctrl.start = is_op && !issued_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			issued_q <= 1'b0;
			out_valid_q <= 1'b0;
			prev_q <= '0;
			pos_q <= '0;
			vel_q <= '0;
		end else begin
			st_q <= st_d;
			if (md_done) begin
				issued_q <= 1'b0;
			end else if (md_ctrl.start) begin
				issued_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if ((st_q == ST_DV) && md_done) begin
				prev_q <= x_q;
				pos_q <= y1_q;
				vel_q <= sat_dw(WW'(vel_q) + WW'(md_result));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_q <= sat_dw(WW'(target));
			t_q <= t_clamped;
		end
		if (md_done) begin
			unique case (st_q)
				ST_TSQ: begin
					sum_q <= sat_dw(WW'(md_result >>> 2)
						+ WW'($signed({2'b00, k1_q[COEF_W-1:1]})));
				end
				ST_LIM: begin
					stab_q <= k2_below;
					k2eff_q <= k2_below ? CW'(md_result) : CW'(k2_q);
				end
				ST_DX: begin
					dx_q <= md_result;
				end
				ST_VT: begin
					y1_q <= sat_dw(WW'(pos_q) + WW'(md_result));
				end
				ST_K3: begin
					acc_q <= AW'(x_q) + AW'(md_result) - AW'(y1_q);
				end
				ST_K1: begin
					acc_q <= acc_q - AW'(md_result);
				end
				default: begin
				end
			endcase
		end
		if (out_load) begin
			position_q <= sat_out(WW'(pos_q));
			velocity_q <= sat_out(WW'(vel_q));
			stabilized_q <= stab_q;
		end
	end

	sof_muldiv #(
		.DATA_WIDTH(DW),
		.FRAC_BITS(FRAC_BITS),
		.A_WIDTH(AW),
		.B_WIDTH(BW),
		.C_WIDTH(CW)
	) u_muldiv (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(md_ctrl),
		.op_a(md_a),
		.op_b(md_b),
		.op_c(md_c),
		.done(md_done),
		.result(md_result)
	);

	assign out_valid = out_valid_q;
	assign position = position_q;
	assign velocity = velocity_q;
	assign stabilized = stabilized_q;

endmodule

`default_nettype wire
